// ===== hw/rtl/gdbd_pkg.sv =====
// Shared types, constants and the month table of the Gregorian day-count block.
`timescale 1ns / 1ps
`default_nettype none

package gdbd_pkg;

  // Field widths
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CentW  = 8;   // ceil(year / 100), at most 164
  localparam int unsigned NumW   = 23;  // day number of one date
  localparam int unsigned CountW = 22;

  // Stream widths, rounded up to whole bytes
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 24;

  localparam logic [CountW-1:0] CountMax = '1;

  // Month codes used for clamping
  localparam logic [MonW-1:0] MonJan = 4'd1;
  localparam logic [MonW-1:0] MonFeb = 4'd2;
  localparam logic [MonW-1:0] MonDec = 4'd12;

  // floor(x / 100) as (x * 5243) >> 19, exact for x below 43690
  localparam int unsigned   RecipShift = 19;
  localparam logic [12:0]   RecipMul   = 13'd5243;

  // Queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [DayW-1:0]  day;
    logic [MonW-1:0]  month;  // already clamped to 1..12
    logic [YearW-1:0] year;
    logic [CentW-1:0] cent;   // ceil(year / 100)
  } date_t;

  typedef struct packed {
    date_t start_date;
    date_t end_date;
  } item_t;

  // Days before the given month in a common year
  function automatic logic [8:0] days_before_month(input logic [MonW-1:0] mon);
    logic [8:0] d;
    unique case (mon)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gregorian_days_between_dates.sv =====
// Top level: inclusive day count between two Gregorian dates.
// A date pair passes through the front register, a queue entry, the day-number
// stage and the difference stage. Throughput: one date pair per cycle unless
// the output stalls; the front end holds one item, the back end two, and the
// two-entry queue between them absorbs output stalls.
// Reset: rst_ni clears all valid flags and queue pointers; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_days_between_dates (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // start_day, start_month, start_year, end_day, end_month, end_year, zero pad
  input  wire logic [gdbd_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // day_count, zero pad
  output logic [gdbd_pkg::OutDataW-1:0]      m_axis_tdata_o,
  // order_error
  output logic                               m_axis_tuser_o
);
  import gdbd_pkg::*;

  logic  fr_valid, fr_ready;
  item_t fr_item;
  logic  q_valid, q_ready;
  item_t q_item;

  gdbd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .valid_o         (fr_valid),
    .ready_i         (fr_ready),
    .item_o          (fr_item)
  );

  gdbd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  gdbd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (q_valid),
    .ready_o         (q_ready),
    .item_i          (q_item),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/gdbd_front.sv =====
// Front end: takes date pairs, clamps months and works out the century ceilings.
`timescale 1ns / 1ps
`default_nettype none

module gdbd_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // start_day, start_month, start_year, end_day, end_month, end_year, zero pad
  input  wire logic [gdbd_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output gdbd_pkg::item_t                    item_o
);
  import gdbd_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  accept;

  // Clamp the month and find ceil(year / 100) by reciprocal multiplication
  function automatic date_t classify(input logic [DayW-1:0]  day,
                                     input logic [MonW-1:0]  mon,
                                     input logic [YearW-1:0] year);
    date_t      r;
    logic [YearW:0] y99;
    logic [YearW+13:0] prod;
    y99  = (YearW+1)'(year) + (YearW+1)'(99);
    prod = (YearW+14)'(y99) * (YearW+14)'(RecipMul);
    r.day   = day;
    r.year  = year;
    r.cent  = prod[RecipShift +: CentW];
    if (mon == '0) begin
      r.month = MonJan;
    end else if (mon > MonDec) begin
      r.month = MonDec;
    end else begin
      r.month = mon;
    end
    return r;
  endfunction

  assign s_axis_tready_o = !valid_q || ready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    item_d  = item_q;
    valid_d = valid_q;
    if (accept) begin
      item_d.start_date = classify(s_axis_tdata_i[4:0], s_axis_tdata_i[8:5],
                                   s_axis_tdata_i[22:9]);
      item_d.end_date   = classify(s_axis_tdata_i[27:23], s_axis_tdata_i[31:28],
                                   s_axis_tdata_i[45:32]);
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  // Control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== hw/rtl/gdbd_queue.sv =====
// Two-entry queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none

module gdbd_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire gdbd_pkg::item_t  push_item_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output gdbd_pkg::item_t       pop_item_o
);
  import gdbd_pkg::*;

  item_t             mem_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != QCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Fill count stays within the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QueueDepth))
    else $error("queue fill count beyond depth");

  // A full queue with no pop keeps its count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == QCntW'(QueueDepth) && !pop_ready_i) |=> count_q == QCntW'(QueueDepth))
    else $error("full queue lost or gained an entry without a pop");

  // Pointers meet when the queue is empty or full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == QCntW'(QueueDepth)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

// ===== hw/rtl/gdbd_back.sv =====
// Back end: day numbers of both dates, then the inclusive difference.
`timescale 1ns / 1ps
`default_nettype none

module gdbd_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire gdbd_pkg::item_t               item_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // day_count, zero pad
  output logic [gdbd_pkg::OutDataW-1:0]      m_axis_tdata_o,
  // order_error
  output logic                               m_axis_tuser_o
);
  import gdbd_pkg::*;

  logic              s1_valid_q, s1_valid_d;
  logic [NumW-1:0]   s_num_q, s_num_d, e_num_q, e_num_d;
  logic              out_valid_q, out_valid_d;
  logic [CountW-1:0] count_q, count_d;
  logic              error_q, error_d;
  logic              s1_ready;
  logic [NumW-1:0]   diff;

  // Days in years 0..y-1, months before, leap day and day of month
  function automatic logic [NumW-1:0] day_number(input date_t d);
    logic [YearW:0]   q4;
    logic [CentW-1:0] q400;
    logic [YearW:0]   c100;
    logic             div100, leap, add_leap;
    logic [NumW-1:0]  n;
    q4       = ((YearW+1)'(d.year) + (YearW+1)'(3)) >> 2;
    q400     = (d.cent + CentW'(3)) >> 2;
    c100     = (YearW+1)'(d.cent) * (YearW+1)'(100);
    div100   = (c100 == (YearW+1)'(d.year));
    leap     = (d.year[1:0] == 2'b00) && (!div100 || d.cent[1:0] == 2'b00);
    add_leap = leap && (d.month > MonFeb);
    n = NumW'(d.year) * NumW'(365) + NumW'(q4) - NumW'(d.cent) + NumW'(q400)
        + NumW'(days_before_month(d.month)) + NumW'(add_leap) + NumW'(d.day);
    return n;
  endfunction

  assign s1_ready = !out_valid_q || m_axis_tready_i;
  assign ready_o  = !s1_valid_q || s1_ready;
  assign diff     = e_num_q - s_num_q + NumW'(1);

  // Stage one: day numbers
  always_comb begin
    s1_valid_d = s1_valid_q;
    s_num_d    = s_num_q;
    e_num_d    = e_num_q;
    if (valid_i && ready_o) begin
      s1_valid_d = 1'b1;
      s_num_d    = day_number(item_i.start_date);
      e_num_d    = day_number(item_i.end_date);
    end else if (s1_ready) begin
      s1_valid_d = 1'b0;
    end
  end

  // Stage two: order check, difference and saturation
  always_comb begin
    out_valid_d = out_valid_q;
    count_d     = count_q;
    error_d     = error_q;
    if (s1_valid_q && s1_ready) begin
      out_valid_d = 1'b1;
      if (e_num_q < s_num_q) begin
        error_d = 1'b1;
        count_d = '0;
      end else begin
        error_d = 1'b0;
        count_d = (diff > NumW'(CountMax)) ? CountMax : diff[CountW-1:0];
      end
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_num_q <= s_num_d;
    e_num_q <= e_num_d;
    count_q <= count_d;
    error_q <= error_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'(count_q);
  assign m_axis_tuser_o  = error_q;

  // An order error always carries a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && error_q) |-> count_q == '0)
    else $error("order error with non-zero count");

  // A good result counts at least one day
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !error_q) |-> count_q != '0)
    else $error("in-order result with zero count");

  // A stage-one item that the output can take is valid at the output in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_ready) |=> out_valid_q)
    else $error("stage one item dropped");

endmodule

`default_nettype wire
